// ===== sv/swm_pkg.sv =====
// swm_pkg: shared constants, types and register codes of the sliding window median filter
// depends on nothing; used by the interfaces, the line buffer, the sort cells and the top level
package swm_pkg;

    localparam int WINDOW_SIZE = 3;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;

    localparam int RADIUS     = (WINDOW_SIZE - 1) / 2;
    localparam int CELLS_N    = WINDOW_SIZE * WINDOW_SIZE;
    localparam int SORT_CELLS = (CELLS_N + 1) / 2;
    localparam int MED_IDX    = (CELLS_N - 1) / 2;
    localparam int LINES      = WINDOW_SIZE - 1;

    localparam int PIX_W      = 8;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = ADDR_W + 1;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;

    localparam int RESET_WIDTH  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic [0:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [LINES-1:0] line_col_t;
    typedef pix_t [WINDOW_SIZE-1:0] win_col_t;
    typedef pix_t [CELLS_N-1:0] win_vec_t;

    // one window on its way through the sort chain
    typedef struct packed {
        logic             vld;
        logic             full;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        win_vec_t         vals;
    } sort_item_t;

endpackage

// ===== sv/swm_pixel_if.sv =====
// swm_pixel_if: valid/ready channel carrying one pixel item
// depends on swm_pkg
interface swm_pixel_if;
    logic                      valid;
    logic                      ready;
    logic [swm_pkg::PIX_W-1:0] pixel_value;
    logic                      frame_start;

    modport source (output valid, output pixel_value, output frame_start, input ready);
    modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

// ===== sv/swm_median_if.sv =====
// swm_median_if: valid/ready channel carrying one median result item
// depends on swm_pkg for field widths
interface swm_median_if;
    logic                      valid;
    logic                      ready;
    logic [swm_pkg::PIX_W-1:0] median_value;
    logic                      window_full;
    logic [swm_pkg::ROW_W-1:0] center_row;
    logic [swm_pkg::COL_W-1:0] center_col;

    modport source (output valid, output median_value, output window_full,
                    output center_row, output center_col, input ready);
    modport sink   (input valid, input median_value, input window_full,
                    input center_row, input center_col, output ready);
endinterface

// ===== sv/sliding_window_median_top.sv =====
// sliding_window_median_top: streaming 3x3 median filter over a raster grey image
// depends on swm_pkg, swm_pixel_if, swm_median_if, swm_line_buf, swm_sort_cell
//
//  port       | kind            | carries
//  -----------+-----------------+------------------------------------------------
//  pixel      | item in, sink   | pixel_value, frame_start
//  median     | item out, source| median_value, window_full, center_row, center_col
//  cfg_*      | register write  | image_width (index 0), image_height (index 1)
//
// one item per clock while no result is held at the output; a taken item passes the
// line buffer read stage, the window stage, then the sort cells, the last of which is
// the output register
// the line buffer has one read and one write port; a same-column write/read pair
// (one-pixel rows) is covered by a forwarding register
// reset clears counters, valid bits and the window; the line store is not cleared
// a held result freezes the whole pipeline; bubbles travel along with it
module sliding_window_median_top
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  swm_pkg::cfg_reg_t              cfg_addr,
    input  logic [swm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    swm_pixel_if.sink                      pixel,
    swm_median_if.source                   median
);

    // configuration, stored already clamped to the legal range
    logic [swm_pkg::WIDTH_W-1:0]   width_reg;
    logic [swm_pkg::WIDTH_W-1:0]   width_next;
    logic [swm_pkg::HEIGHT_W-1:0]  height_reg;
    logic [swm_pkg::HEIGHT_W-1:0]  height_next;
    logic [swm_pkg::CFG_WID_W-1:0] wid_raw;
    logic [swm_pkg::CFG_HGT_W-1:0] hgt_raw;

    // raster position
    logic [swm_pkg::ADDR_W-1:0]    col_count_reg;
    logic [swm_pkg::ADDR_W-1:0]    col_count_next;
    logic [swm_pkg::ROW_W-1:0]     row_count_reg;
    logic [swm_pkg::ROW_W-1:0]     row_count_next;
    logic [swm_pkg::ADDR_W-1:0]    col_base;
    logic [swm_pkg::ROW_W-1:0]     row_base;
    logic [swm_pkg::ADDR_W-1:0]    cur_col;
    logic [swm_pkg::ROW_W-1:0]     cur_row;
    logic [swm_pkg::WIDTH_W-1:0]   col_inc;
    logic [swm_pkg::HEIGHT_W-1:0]  row_inc;
    logic                          cur_full;
    logic [swm_pkg::ROW_W-1:0]     cur_crow;
    logic [swm_pkg::COL_W-1:0]     cur_ccol;

    logic                          pipe_en;
    logic                          accept;

    // stage 1: line buffer read in flight
    logic                          s1_vld_reg;
    swm_pkg::pix_t                 s1_pix_reg;
    logic [swm_pkg::ADDR_W-1:0]    s1_addr_reg;
    logic                          s1_full_reg;
    logic [swm_pkg::ROW_W-1:0]     s1_row_reg;
    logic [swm_pkg::COL_W-1:0]     s1_col_reg;
    logic                          fwd_reg;
    logic                          fwd_next;
    swm_pkg::line_col_t            fwd_data_reg;
    swm_pkg::line_col_t            rd_data;
    swm_pkg::line_col_t            old_col;
    swm_pkg::line_col_t            wr_data;
    swm_pkg::win_col_t             new_col;

    // stage 2: window
    swm_pkg::win_col_t [swm_pkg::WINDOW_SIZE-1:0] win_reg;
    logic                          s2_vld_reg;
    logic                          s2_full_reg;
    logic [swm_pkg::ROW_W-1:0]     s2_row_reg;
    logic [swm_pkg::COL_W-1:0]     s2_col_reg;

    swm_pkg::sort_item_t           chain [swm_pkg::SORT_CELLS+1];
    swm_pkg::sort_item_t           out_item;

    // ---------------- configuration ----------------
    assign wid_raw = cfg_wdata[swm_pkg::CFG_WID_W-1:0];
    assign hgt_raw = cfg_wdata[swm_pkg::CFG_HGT_W-1:0];

    always_comb
    begin
        // zero acts as one, oversize saturates
        if (wid_raw == '0)
            width_next = swm_pkg::WIDTH_W'(1);
        else if (wid_raw > swm_pkg::CFG_WID_W'(swm_pkg::MAX_WIDTH))
            width_next = swm_pkg::WIDTH_W'(swm_pkg::MAX_WIDTH);
        else
            width_next = swm_pkg::WIDTH_W'(wid_raw);
        if (hgt_raw == '0)
            height_next = swm_pkg::HEIGHT_W'(1);
        else if (hgt_raw > swm_pkg::CFG_HGT_W'(swm_pkg::MAX_HEIGHT))
            height_next = swm_pkg::HEIGHT_W'(swm_pkg::MAX_HEIGHT);
        else
            height_next = swm_pkg::HEIGHT_W'(hgt_raw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= swm_pkg::WIDTH_W'(swm_pkg::RESET_WIDTH);
            height_reg <= swm_pkg::HEIGHT_W'(swm_pkg::RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                swm_pkg::REG_WIDTH:  width_reg  <= width_next;
                swm_pkg::REG_HEIGHT: height_reg <= height_next;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    // ---------------- handshake ----------------
    // the pipeline only stops when a finished result is held at the output
    assign pipe_en     = !(out_item.vld && !median.ready);
    assign pixel.ready = pipe_en;
    assign accept      = pixel.valid && pipe_en;

    // ---------------- raster position of the incoming item ----------------
    always_comb
    begin
        col_base = pixel.frame_start ? '0 : col_count_reg;
        row_base = pixel.frame_start ? '0 : row_count_reg;
        // counters left past the end by a geometry change wrap to zero
        cur_col  = ({1'b0, col_base} >= width_reg) ? '0 : col_base;
        cur_row  = ({1'b0, row_base} >= height_reg) ? '0 : row_base;

        col_inc  = {1'b0, cur_col} + swm_pkg::WIDTH_W'(1);
        row_inc  = {1'b0, cur_row} + swm_pkg::HEIGHT_W'(1);
        if (col_inc >= width_reg)
        begin
            col_count_next = '0;
            row_count_next = (row_inc >= height_reg) ? '0 : row_inc[swm_pkg::ROW_W-1:0];
        end
        else
        begin
            col_count_next = col_inc[swm_pkg::ADDR_W-1:0];
            row_count_next = cur_row;
        end

        cur_full = (cur_row >= swm_pkg::ROW_W'(swm_pkg::WINDOW_SIZE - 1)) &&
                   (cur_col >= swm_pkg::ADDR_W'(swm_pkg::WINDOW_SIZE - 1));
        // non-full windows report zero coordinates
        cur_crow = cur_full ? (cur_row - swm_pkg::ROW_W'(swm_pkg::RADIUS)) : '0;
        cur_ccol = cur_full ? swm_pkg::COL_W'(cur_col - swm_pkg::ADDR_W'(swm_pkg::RADIUS))
                            : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    // ---------------- stage 1: line buffer read ----------------
    // a read of the column that stage 1 is writing at the same edge gets the
    // written data through the forwarding register instead of the stale word
    assign fwd_next = s1_vld_reg && (cur_col == s1_addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            fwd_reg    <= 1'b0;
        end
        else if (pipe_en)
        begin
            s1_vld_reg <= pixel.valid;
            fwd_reg    <= pixel.valid && fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pixel.pixel_value;
            s1_addr_reg  <= cur_col;
            s1_full_reg  <= cur_full;
            s1_row_reg   <= cur_crow;
            s1_col_reg   <= cur_ccol;
            fwd_data_reg <= wr_data;
        end
    end

    swm_line_buf u_line_buf
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (rd_data),
        .wr_en   (pipe_en && s1_vld_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wr_data)
    );

    always_comb
    begin
        old_col = fwd_reg ? fwd_data_reg : rd_data;
        // line k holds the row k+1 above; the new pixel enters line 0
        wr_data[0] = s1_pix_reg;
        for (int k = 1; k < swm_pkg::LINES; k++)
        begin
            wr_data[k] = old_col[k-1];
        end
        // window column, top row first
        new_col[swm_pkg::WINDOW_SIZE-1] = s1_pix_reg;
        for (int k = 0; k < swm_pkg::LINES; k++)
        begin
            new_col[swm_pkg::WINDOW_SIZE-2-k] = old_col[k];
        end
    end

    // ---------------- stage 2: window shift ----------------
    // columns move one place left per item, the new column enters at the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            s2_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            s2_vld_reg <= s1_vld_reg;
            if (s1_vld_reg)
            begin
                for (int j = 0; j < swm_pkg::WINDOW_SIZE - 1; j++)
                begin
                    win_reg[j] <= win_reg[j+1];
                end
                win_reg[swm_pkg::WINDOW_SIZE-1] <= new_col;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en && s1_vld_reg)
        begin
            s2_full_reg <= s1_full_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
    end

    always_comb
    begin
        chain[0].vld  = s2_vld_reg;
        chain[0].full = s2_full_reg;
        chain[0].row  = s2_row_reg;
        chain[0].col  = s2_col_reg;
        for (int j = 0; j < swm_pkg::WINDOW_SIZE; j++)
        begin
            for (int i = 0; i < swm_pkg::WINDOW_SIZE; i++)
            begin
                chain[0].vals[j*swm_pkg::WINDOW_SIZE+i] = win_reg[j][i];
            end
        end
    end

    // ---------------- sort chain ----------------
    // each cell does two compare-exchange layers, enough cells for a full sort
    for (genvar g = 0; g < swm_pkg::SORT_CELLS; g++)
    begin : g_sort
        swm_sort_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (pipe_en),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // ---------------- output ----------------
    // the last cell's register is the output register
    assign out_item            = chain[swm_pkg::SORT_CELLS];
    assign median.valid        = out_item.vld;
    assign median.median_value = out_item.full ? out_item.vals[swm_pkg::MED_IDX] : '0;
    assign median.window_full  = out_item.full;
    assign median.center_row   = out_item.row;
    assign median.center_col   = out_item.col;

    // ---------------- checks ----------------
    // a non-full window must report every field as zero
    a_zero_border: assert property (@(posedge clk) disable iff (!rst_n)
        (median.valid && !median.window_full) |->
        (median.median_value == '0 && median.center_row == '0 && median.center_col == '0))
        else $error("non-full window reports nonzero fields");

    // a taken pixel always lands in stage 1
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_vld_reg)
        else $error("accepted item lost before stage 1");

    // forwarding only ever applies to a live stage 1 item
    a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg |-> s1_vld_reg)
        else $error("forwarding flag without stage 1 item");

    // a held result freezes the window
    a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(win_reg))
        else $error("window moved during a stall");

    // a stalled stage 1 item keeps its column address
    a_addr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!pipe_en && s1_vld_reg) |=> ($stable(s1_addr_reg) && s1_vld_reg))
        else $error("stage 1 item changed during a stall");

endmodule

// ===== sv/swm_line_buf.sv =====
// swm_line_buf: line store, one entry per column holding the stacked pixels of earlier rows
// depends on swm_pkg
module swm_line_buf
(
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [swm_pkg::ADDR_W-1:0] rd_addr,
    output swm_pkg::line_col_t         rd_data,
    input  logic                       wr_en,
    input  logic [swm_pkg::ADDR_W-1:0] wr_addr,
    input  swm_pkg::line_col_t         wr_data
);

    swm_pkg::line_col_t line_mem [swm_pkg::MAX_WIDTH];
    swm_pkg::line_col_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/swm_sort_cell.sv =====
// swm_sort_cell: one cell of the odd-even transposition sort chain (even then odd layer)
// depends on swm_pkg
module swm_sort_cell
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  swm_pkg::sort_item_t din,
    output swm_pkg::sort_item_t dout
);

    swm_pkg::win_vec_t   even_vals;
    swm_pkg::win_vec_t   odd_vals;
    swm_pkg::sort_item_t item_reg;
    swm_pkg::sort_item_t item_next;
    logic                vld_reg;

    always_comb
    begin
        even_vals = din.vals;
        for (int i = 0; i < swm_pkg::CELLS_N / 2; i++)
        begin
            if (din.vals[2*i] > din.vals[2*i+1])
            begin
                even_vals[2*i]   = din.vals[2*i+1];
                even_vals[2*i+1] = din.vals[2*i];
            end
        end
        odd_vals = even_vals;
        for (int i = 0; i < (swm_pkg::CELLS_N - 1) / 2; i++)
        begin
            if (even_vals[2*i+1] > even_vals[2*i+2])
            begin
                odd_vals[2*i+1] = even_vals[2*i+2];
                odd_vals[2*i+2] = even_vals[2*i+1];
            end
        end
        item_next      = din;
        item_next.vals = odd_vals;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= din.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && din.vld)
        begin
            item_reg <= item_next;
        end
    end

    always_comb
    begin
        dout     = item_reg;
        dout.vld = vld_reg;
    end

endmodule
